### hw/rtl/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection pipeline.
// No dependencies; used by rti_div, ray_triangle_intersect and rti_checker.
package rti_pkg;

  // determinant threshold register
  localparam int unsigned EPS_BITS = 40;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 40'd168;

  // quotient format: magnitude bits produced by the divider, fractional bits
  localparam int unsigned Q_BITS = 32;
  localparam int unsigned Q_FRAC = 16;

  // result formats
  localparam int unsigned BARY_W = 17;
  localparam int unsigned DIST_W = 32;
  localparam logic [17:0] BARY_CAP = 18'd65537;
  localparam logic [18:0] ONE_Q16 = 19'd65536;
  localparam logic [DIST_W-1:0] DIST_CAP = 32'h8000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;

  // per-item control that rides alongside the divider
  typedef struct packed {
    logic cull;        // culling test selected
    logic early_miss;  // rejected before the quotients are known
    logic neg_u;       // sign of u quotient
    logic neg_v;       // sign of v quotient
    logic neg_t;       // sign of t quotient
  } rti_side_t;

endpackage

### hw/rtl/rti_geom.sv
// Geometry front end: edge vectors, cross products and dot products.
// Three register stages; uses no package items.
module rti_geom #(
  parameter int unsigned CW = 16,
  parameter int unsigned DW = 3 * (CW + 1) + 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 cull_i,
  input  logic [3*CW-1:0]      orig_i,
  input  logic [3*CW-1:0]      dir_i,
  input  logic [3*CW-1:0]      v0_i,
  input  logic [3*CW-1:0]      v1_i,
  input  logic [3*CW-1:0]      v2_i,
  output logic                 valid_o,
  output logic                 cull_o,
  output logic signed [DW-1:0] det_o,
  output logic signed [DW-1:0] un_o,
  output logic signed [DW-1:0] vn_o,
  output logic signed [DW-1:0] tn_o
);

  localparam int unsigned EW = CW + 1;
  localparam int unsigned XW = 2 * EW + 1;
  localparam int unsigned PW = EW + XW;

  function automatic logic signed [XW-1:0] xcomp(
    logic signed [EW-1:0] a, logic signed [EW-1:0] b,
    logic signed [EW-1:0] c, logic signed [EW-1:0] d
  );
    logic signed [2*EW-1:0] p;
    logic signed [2*EW-1:0] q;
    p = a * b;
    q = c * d;
    return XW'(p) - XW'(q);
  endfunction

  function automatic logic signed [DW-1:0] dotp(
    logic signed [EW-1:0] a0, logic signed [EW-1:0] a1, logic signed [EW-1:0] a2,
    logic signed [XW-1:0] b0, logic signed [XW-1:0] b1, logic signed [XW-1:0] b2
  );
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    p0 = a0 * b0;
    p1 = a1 * b1;
    p2 = a2 * b2;
    return DW'(p0) + DW'(p1) + DW'(p2);
  endfunction

  // stage 1: unpack and subtract
  logic signed [CW-1:0] o_c [3];
  logic signed [CW-1:0] d_c [3];
  logic signed [CW-1:0] p0_c [3];
  logic signed [CW-1:0] p1_c [3];
  logic signed [CW-1:0] p2_c [3];
  logic signed [EW-1:0] e1_d [3];
  logic signed [EW-1:0] e2_d [3];
  logic signed [EW-1:0] tv_d [3];
  logic signed [EW-1:0] dr_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_c[i]  = signed'(orig_i[i*CW +: CW]);
      d_c[i]  = signed'(dir_i[i*CW +: CW]);
      p0_c[i] = signed'(v0_i[i*CW +: CW]);
      p1_c[i] = signed'(v1_i[i*CW +: CW]);
      p2_c[i] = signed'(v2_i[i*CW +: CW]);
      e1_d[i] = EW'(p1_c[i]) - EW'(p0_c[i]);
      e2_d[i] = EW'(p2_c[i]) - EW'(p0_c[i]);
      tv_d[i] = EW'(o_c[i]) - EW'(p0_c[i]);
      dr_d[i] = EW'(d_c[i]);
    end
  end

  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [EW-1:0] tv_q [3];
  logic signed [EW-1:0] dr_q [3];
  logic                 s1_valid_q, s1_cull_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
      tv_q <= tv_d;
      dr_q <= dr_d;
      s1_cull_q <= cull_i;
    end
  end

  // stage 2: pvec = dir x edge2, qvec = tvec x edge1
  logic signed [XW-1:0] pv_d [3];
  logic signed [XW-1:0] qv_d [3];

  always_comb begin
    pv_d[0] = xcomp(dr_q[1], e2_q[2], dr_q[2], e2_q[1]);
    pv_d[1] = xcomp(dr_q[2], e2_q[0], dr_q[0], e2_q[2]);
    pv_d[2] = xcomp(dr_q[0], e2_q[1], dr_q[1], e2_q[0]);
    qv_d[0] = xcomp(tv_q[1], e1_q[2], tv_q[2], e1_q[1]);
    qv_d[1] = xcomp(tv_q[2], e1_q[0], tv_q[0], e1_q[2]);
    qv_d[2] = xcomp(tv_q[0], e1_q[1], tv_q[1], e1_q[0]);
  end

  logic signed [XW-1:0] pv_q [3];
  logic signed [XW-1:0] qv_q [3];
  logic signed [EW-1:0] e1b_q [3];
  logic signed [EW-1:0] e2b_q [3];
  logic signed [EW-1:0] tvb_q [3];
  logic signed [EW-1:0] drb_q [3];
  logic                 s2_valid_q, s2_cull_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pv_q  <= pv_d;
      qv_q  <= qv_d;
      e1b_q <= e1_q;
      e2b_q <= e2_q;
      tvb_q <= tv_q;
      drb_q <= dr_q;
      s2_cull_q <= s1_cull_q;
    end
  end

  // stage 3: the four dot products
  logic signed [DW-1:0] det_q, un_q, vn_q, tn_q;
  logic                 s3_valid_q, s3_cull_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= dotp(e1b_q[0], e1b_q[1], e1b_q[2], pv_q[0], pv_q[1], pv_q[2]);
      un_q  <= dotp(tvb_q[0], tvb_q[1], tvb_q[2], pv_q[0], pv_q[1], pv_q[2]);
      vn_q  <= dotp(drb_q[0], drb_q[1], drb_q[2], qv_q[0], qv_q[1], qv_q[2]);
      tn_q  <= dotp(e2b_q[0], e2b_q[1], e2b_q[2], qv_q[0], qv_q[1], qv_q[2]);
      s3_cull_q <= s2_cull_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  assign valid_o = s3_valid_q;
  assign cull_o  = s3_cull_q;
  assign det_o   = det_q;
  assign un_o    = un_q;
  assign vn_o    = vn_q;
  assign tn_o    = tn_q;

endmodule

### hw/rtl/rti_div.sv
// Pipelined restoring divider, one quotient bit per stage, fixed-point result.
// Depends on rti_pkg for the quotient format.
module rti_div #(
  parameter int unsigned NW = 54
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [NW-1:0]              num_i,
  input  logic [NW-1:0]              den_i,
  output logic [rti_pkg::Q_BITS-1:0] quo_o,
  output logic                       ovf_o
);

  localparam int unsigned QB = rti_pkg::Q_BITS;
  localparam int unsigned FB = rti_pkg::Q_FRAC;

  logic [NW-1:0] rem_q [QB+1];
  logic [NW-1:0] den_q [QB+1];
  logic [QB-1:0] low_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic          ovf_q [QB+1];

  // stage 0: scale the dividend, split off the bits still to shift in
  logic [NW+FB-1:0] nn;
  logic [NW-1:0]    top;

  always_comb begin
    nn  = {num_i, FB'(0)};
    top = NW'(nn[NW+FB-1:QB]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= top;
      den_q[0] <= den_i;
      low_q[0] <= nn[QB-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= (top >= den_i);
    end
  end

  // one compare-and-subtract per stage
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [NW:0] r2;
    logic        take;

    always_comb begin
      r2   = {rem_q[k-1], low_q[k-1][QB-1]};
      take = (r2 >= {1'b0, den_q[k-1]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? NW'(r2 - {1'b0, den_q[k-1]}) : r2[NW-1:0];
        den_q[k] <= den_q[k-1];
        low_q[k] <= {low_q[k-1][QB-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][QB-2:0], take};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

### hw/rtl/ray_triangle_intersect.sv
// Ray/triangle intersection pipeline: 3 geometry stages, 1 test stage, 33 divider
// stages, 1 output register; one transaction per cycle unless the output stalls.
// The divider's one-bit-per-stage chain sets the latency.
// A stall on the output freezes the whole pipeline. Async active-low reset clears
// valid bits and sets the threshold eps_q to 168. Uses rti_pkg, rti_geom, rti_div.
module ray_triangle_intersect #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [3*COORD_BITS-1:0]              ray_origin_i,
  input  logic [3*COORD_BITS-1:0]              ray_direction_i,
  input  logic [3*COORD_BITS-1:0]              vertex_0_i,
  input  logic [3*COORD_BITS-1:0]              vertex_1_i,
  input  logic [3*COORD_BITS-1:0]              vertex_2_i,
  input  logic                                 cull_backfaces_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 hit_o,
  output logic [rti_pkg::BARY_W-1:0]           bary_u_o,
  output logic [rti_pkg::BARY_W-1:0]           bary_v_o,
  output logic signed [rti_pkg::DIST_W-1:0]    hit_distance_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rti_pkg::EPS_BITS-1:0]         cfg_data_i
);

  localparam int unsigned DW   = 3 * (COORD_BITS + 1) + 4;
  localparam int unsigned EB   = rti_pkg::EPS_BITS;
  localparam int unsigned CMPW = ((DW > EB) ? DW : EB) + 1;
  localparam int unsigned QB   = rti_pkg::Q_BITS;

  logic en;
  logic out_valid_q;

  // global advance: move when the output register is free or being taken
  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // threshold register
  logic [EB-1:0] eps_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= rti_pkg::EPS_RESET;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  // geometry
  logic                 g_valid, g_cull;
  logic signed [DW-1:0] det, un, vn, tn;

  rti_geom #(.CW(COORD_BITS), .DW(DW)) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .cull_i  (cull_backfaces_i),
    .orig_i  (ray_origin_i),
    .dir_i   (ray_direction_i),
    .v0_i    (vertex_0_i),
    .v1_i    (vertex_1_i),
    .v2_i    (vertex_2_i),
    .valid_o (g_valid),
    .cull_o  (g_cull),
    .det_o   (det),
    .un_o    (un),
    .vn_o    (vn),
    .tn_o    (tn)
  );

  // test stage: determinant threshold, cull bounds, magnitudes for the divider
  function automatic logic [DW-1:0] mag(logic signed [DW-1:0] x);
    return x[DW-1] ? (~unsigned'(x) + 1'b1) : unsigned'(x);
  endfunction

  logic signed [CMPW-1:0] det_x, eps_x;
  logic signed [DW:0]     uv_sum;
  logic [DW-1:0]          mag_det;
  logic                   cull_miss, two_miss;
  rti_pkg::rti_side_t     side_d;

  always_comb begin
    det_x     = CMPW'(det);
    eps_x     = signed'(CMPW'(eps_q));
    mag_det   = mag(det);
    uv_sum    = (DW+1)'(un) + (DW+1)'(vn);
    cull_miss = (det_x < eps_x) || un[DW-1] || (un > det) || vn[DW-1]
                || (uv_sum > (DW+1)'(det));
    two_miss  = (CMPW'(mag_det) < CMPW'(eps_q));
    side_d.cull       = g_cull;
    side_d.early_miss = (det == '0) || (g_cull ? cull_miss : two_miss);
    side_d.neg_u      = un[DW-1] ^ det[DW-1];
    side_d.neg_v      = vn[DW-1] ^ det[DW-1];
    side_d.neg_t      = tn[DW-1] ^ det[DW-1];
  end

  logic               prep_valid_q;
  rti_pkg::rti_side_t prep_side_q;
  logic [DW-1:0]      nu_q, nv_q, nt_q, den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_side_q <= side_d;
      nu_q  <= mag(un);
      nv_q  <= mag(vn);
      nt_q  <= mag(tn);
      den_q <= mag_det;
    end
  end

  // dividers for u, v and t
  logic [QB-1:0] quo_u, quo_v, quo_t;
  logic          ovf_u, ovf_v, ovf_t;

  rti_div #(.NW(DW)) u_div_u (
    .clk_i(clk_i), .en_i(en), .num_i(nu_q), .den_i(den_q), .quo_o(quo_u), .ovf_o(ovf_u)
  );
  rti_div #(.NW(DW)) u_div_v (
    .clk_i(clk_i), .en_i(en), .num_i(nv_q), .den_i(den_q), .quo_o(quo_v), .ovf_o(ovf_v)
  );
  rti_div #(.NW(DW)) u_div_t (
    .clk_i(clk_i), .en_i(en), .num_i(nt_q), .den_i(den_q), .quo_o(quo_t), .ovf_o(ovf_t)
  );

  // control shift line matching the divider depth
  rti_pkg::rti_side_t side_q [QB+1];
  logic               sval_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= prep_side_q;
      for (int k = 1; k <= QB; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
      for (int k = 0; k <= QB; k++) begin
        sval_q[k] <= 1'b0;
      end
    end else if (en) begin
      prep_valid_q <= g_valid;
      sval_q[0]    <= prep_valid_q;
      for (int k = 1; k <= QB; k++) begin
        sval_q[k] <= sval_q[k-1];
      end
    end
  end

  // final stage: saturation, two-sided bounds, sign and miss zeroing
  rti_pkg::rti_side_t         fs;
  logic [17:0]                mu, mv;
  logic [rti_pkg::DIST_W-1:0] mt, t_val;
  logic                       bound_miss, hit_d;

  always_comb begin
    fs = side_q[QB];
    mu = (ovf_u || (quo_u > QB'(rti_pkg::BARY_CAP))) ? rti_pkg::BARY_CAP : quo_u[17:0];
    mv = (ovf_v || (quo_v > QB'(rti_pkg::BARY_CAP))) ? rti_pkg::BARY_CAP : quo_v[17:0];
    mt = (ovf_t || quo_t[QB-1]) ? rti_pkg::DIST_CAP : quo_t[rti_pkg::DIST_W-1:0];
    bound_miss = (fs.neg_u && (mu != '0)) || (!fs.neg_u && (19'(mu) > rti_pkg::ONE_Q16))
                 || (fs.neg_v && (mv != '0)) || (!fs.neg_v && (19'(mv) > rti_pkg::ONE_Q16))
                 || ((19'(mu) + 19'(mv)) > rti_pkg::ONE_Q16);
    hit_d = !fs.early_miss && !(!fs.cull && bound_miss);
    if (fs.neg_t) begin
      t_val = '0 - mt;
    end else begin
      t_val = mt[rti_pkg::DIST_W-1] ? rti_pkg::DIST_MAX : mt;
    end
  end

  // output register
  logic                       hit_q;
  logic [rti_pkg::BARY_W-1:0] u_q, v_q;
  logic [rti_pkg::DIST_W-1:0] t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
      u_q   <= hit_d ? mu[rti_pkg::BARY_W-1:0] : '0;
      v_q   <= hit_d ? mv[rti_pkg::BARY_W-1:0] : '0;
      t_q   <= hit_d ? t_val : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sval_q[QB];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign bary_u_o       = u_q;
  assign bary_v_o       = v_q;
  assign hit_distance_o = signed'(t_q);

endmodule

### hw/rtl/rti_checker.sv
// Port-level checks for ray_triangle_intersect, attached by bind.
// Depends on rti_pkg for result widths.
module rti_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              hit_o,
  input logic [rti_pkg::BARY_W-1:0]        bary_u_o,
  input logic [rti_pkg::BARY_W-1:0]        bary_v_o,
  input logic signed [rti_pkg::DIST_W-1:0] hit_distance_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input stalls only when a result is held back downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a miss carries zero values
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> bary_u_o == '0 && bary_v_o == '0 && hit_distance_o == '0)
    else $error("miss with nonzero values");

  // a hit lies inside the triangle
  a_hit_bary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> (19'(bary_u_o) + 19'(bary_v_o)) <= rti_pkg::ONE_Q16)
    else $error("hit outside barycentric bounds");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .hit_o          (hit_o),
  .bary_u_o       (bary_u_o),
  .bary_v_o       (bary_v_o),
  .hit_distance_o (hit_distance_o)
);
